// File: sv/dprob_pkg.sv
package dprob_pkg;

	// default buffer depth
	localparam int ROB_DEPTH_DEF = 16;

	// field widths
	localparam int INSTR_W = 32;
	localparam int DEST_W  = 5;
	localparam int SLOT_W  = 4;
	localparam int IDX_W   = 4;
	localparam int ENTRY_W = INSTR_W + DEST_W;

	// stream payload widths
	localparam int IN_DATA_W  = 88;
	localparam int IN_USER_W  = 5;
	localparam int OUT_DATA_W = 88;
	localparam int OUT_USER_W = 2;

	// instruction word that is never allocated
	localparam logic [INSTR_W-1:0] NOP_WORD = 32'h0000_0000;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic accept;   // take a request, update flags and pointers
		logic rd_next;  // read the second head entry
		logic cap_a;    // capture the first commit entry
		logic cap_b;    // capture the second commit entry
		logic wr_a;     // write the first allocation
		logic wr_b;     // write the second allocation
		logic load_out; // load the result register
	} dprob_cmd_t;

endpackage

// File: sv/dual_port_reorder_buffer_top.sv
// Dual-issue reorder buffer with in-order commit. Each request is one pipeline
// tick: up to two head entries that are valid and no longer pending retire,
// then up to two non-NOP instructions allocate at the tail (dropped when the
// tail entry is still occupied), then the ALU, memory and mul/div writebacks
// clear the pending bits of the slots they name. Every request yields exactly
// one result carrying both commit slots and the head and tail after the tick.
// The result register loads in the WRB state, or later in PUSH while the
// previous result is not yet taken; the sequencer then returns to idle, so a
// new request is taken only after the last one is through. The flags and
// pointers update at acceptance; the instruction and destination store is a
// single RAM with one read and one write port, so the two head reads and the
// two tail writes fall on acceptance, RDB, WRA, WRB. The next request is taken
// as soon as that sequence ends, while the previous result may still wait on
// m_axis; a result that cannot be loaded yet holds the sequence until the
// earlier one is taken.
module dual_port_reorder_buffer_top
	import dprob_pkg::*;
#(
	parameter int ROB_DEPTH = ROB_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// alloc_a_instr[31:0], alloc_a_dest[36:32], alloc_b_instr[68:37],
	// alloc_b_dest[73:69], fill_alu_slot[77:74], fill_mem_slot[81:78],
	// fill_muldiv_slot[85:82], zero [87:86]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// alloc_a_valid[0], alloc_b_valid[1], fill_alu_valid[2],
	// fill_mem_valid[3], fill_muldiv_valid[4]
	input  logic [IN_USER_W-1:0]  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// commit_a_instr[31:0], commit_a_dest[36:32], commit_b_instr[68:37],
	// commit_b_dest[73:69], head_index[77:74], tail_index[81:78], zero [87:82]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// commit_a_valid[0], commit_b_valid[1]
	output logic [OUT_USER_W-1:0] m_axis_tuser
);

	dprob_cmd_t cmd;

	dprob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	dprob_dp #(
		.ROB_DEPTH (ROB_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (s_axis_tdata),
		.in_user  (s_axis_tuser),
		.out_data (m_axis_tdata),
		.out_user (m_axis_tuser)
	);

endmodule

// File: sv/dprob_ram.sv
module dprob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one port, read one port with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/dprob_ctrl.sv
module dprob_ctrl
	import dprob_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output dprob_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RDB,
		ST_WRA,
		ST_WRB,
		ST_PUSH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;

	assign can_load  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// decode commands from state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
			end
			ST_RDB: begin
				cmd.rd_next = 1'b1;
				cmd.cap_a   = 1'b1;
			end
			ST_WRA: begin
				cmd.rd_next = 1'b1;
				cmd.cap_b   = 1'b1;
				cmd.wr_a    = 1'b1;
			end
			ST_WRB: begin
				cmd.wr_b     = 1'b1;
				cmd.load_out = can_load;
			end
			ST_PUSH: begin
				cmd.load_out = can_load;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// advance the sequence, hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RDB;
					end
				end
				ST_RDB: begin
					state_q <= ST_WRA;
				end
				ST_WRA: begin
					state_q <= ST_WRB;
				end
				ST_WRB: begin
					state_q <= can_load ? ST_IDLE : ST_PUSH;
				end
				ST_PUSH: begin
					if (can_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_then_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.cap_a)
		else $error("capture of first commit entry did not follow a request");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid)
		else $error("result register loaded but not presented");
`endif

endmodule

// File: sv/dprob_dp.sv
module dprob_dp
	import dprob_pkg::*;
#(
	parameter int ROB_DEPTH = ROB_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dprob_cmd_t            cmd,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic [IN_USER_W-1:0]  in_user,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [OUT_USER_W-1:0] out_user
);

	localparam int PTR_W = $clog2(ROB_DEPTH);

	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [ROB_DEPTH-1:0] flags_t;

	// wrap-around increment
	function automatic ptr_t next_ptr(input ptr_t p);
		ptr_t r;
		if (p == PTR_W'(ROB_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = PTR_W'(p + 1'b1);
		end
		return r;
	endfunction

	// writeback slot to buffer index
	function automatic ptr_t slot_ptr(input logic [SLOT_W-1:0] s);
		logic [PTR_W+SLOT_W-1:0] x;
		x = {{PTR_W{1'b0}}, s};
		return x[PTR_W-1:0];
	endfunction

	// writeback slot lies inside the buffer
	function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
		return ({5'b0, s} < 9'(ROB_DEPTH));
	endfunction

	// request fields
	logic                a_valid, b_valid;
	logic [INSTR_W-1:0]  a_instr, b_instr;
	logic [DEST_W-1:0]   a_dest, b_dest;
	logic                alu_valid, mem_valid, md_valid;
	logic [SLOT_W-1:0]   alu_slot, mem_slot, md_slot;

	assign a_valid   = in_user[0];
	assign b_valid   = in_user[1];
	assign alu_valid = in_user[2];
	assign mem_valid = in_user[3];
	assign md_valid  = in_user[4];
	assign a_instr   = in_data[31:0];
	assign a_dest    = in_data[36:32];
	assign b_instr   = in_data[68:37];
	assign b_dest    = in_data[73:69];
	assign alu_slot  = in_data[77:74];
	assign mem_slot  = in_data[81:78];
	assign md_slot   = in_data[85:82];

	// state
	flags_t valid_q, pend_q;
	ptr_t   head_q, tail_q;

	// per-request decisions
	logic   ca_q, cb_q, aa_q, ab_q;
	ptr_t   rdb_addr_q, wa_addr_q, wb_addr_q;
	logic [ENTRY_W-1:0] wa_data_q, wb_data_q;
	logic [ENTRY_W-1:0] ca_entry_q, cb_entry_q;

	// next-state logic
	logic   ca, cb, aa, ab;
	ptr_t   h1, h2, t1, t2;
	flags_t v1, v2, v3, v4, p3, p4, fill_mask;

	always_comb begin
		// commits, oldest first
		ca = valid_q[head_q] & ~pend_q[head_q];
		v1 = valid_q;
		h1 = head_q;
		if (ca) begin
			v1[head_q] = 1'b0;
			h1         = next_ptr(head_q);
		end
		cb = v1[h1] & ~pend_q[h1];
		v2 = v1;
		h2 = h1;
		if (cb) begin
			v2[h1] = 1'b0;
			h2     = next_ptr(h1);
		end

		// allocations, first then second
		aa = a_valid & (a_instr != NOP_WORD) & ~v2[tail_q];
		v3 = v2;
		p3 = pend_q;
		t1 = tail_q;
		if (aa) begin
			v3[tail_q] = 1'b1;
			p3[tail_q] = 1'b1;
			t1         = next_ptr(tail_q);
		end
		ab = b_valid & (b_instr != NOP_WORD) & ~v3[t1];
		v4 = v3;
		p4 = p3;
		t2 = t1;
		if (ab) begin
			v4[t1] = 1'b1;
			p4[t1] = 1'b1;
			t2     = next_ptr(t1);
		end

		// writebacks clear pending
		fill_mask = '0;
		if (alu_valid && slot_ok(alu_slot)) begin
			fill_mask[slot_ptr(alu_slot)] = 1'b1;
		end
		if (mem_valid && slot_ok(mem_slot)) begin
			fill_mask[slot_ptr(mem_slot)] = 1'b1;
		end
		if (md_valid && slot_ok(md_slot)) begin
			fill_mask[slot_ptr(md_slot)] = 1'b1;
		end
	end

	// update flags and pointers, latch decisions on a request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			pend_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			ca_q    <= 1'b0;
			cb_q    <= 1'b0;
			aa_q    <= 1'b0;
			ab_q    <= 1'b0;
		end else if (cmd.accept) begin
			valid_q <= v4;
			pend_q  <= p4 & ~fill_mask;
			head_q  <= h2;
			tail_q  <= t2;
			ca_q    <= ca;
			cb_q    <= cb;
			aa_q    <= aa;
			ab_q    <= ab;
		end
	end

	// request payload for the entry store
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdb_addr_q <= h1;
			wa_addr_q  <= tail_q;
			wb_addr_q  <= t1;
			wa_data_q  <= {a_dest, a_instr};
			wb_data_q  <= {b_dest, b_instr};
		end
	end

	// entry store
	logic               ram_we;
	ptr_t               ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	assign ram_raddr = cmd.rd_next ? rdb_addr_q : head_q;
	assign ram_we    = (cmd.wr_a & aa_q) | (cmd.wr_b & ab_q);
	assign ram_waddr = cmd.wr_b ? wb_addr_q : wa_addr_q;
	assign ram_wdata = cmd.wr_b ? wb_data_q : wa_data_q;

	dprob_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ROB_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// capture retired entries, zero when nothing retires
	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			ca_entry_q <= ca_q ? ram_rdata : '0;
		end
		if (cmd.cap_b) begin
			cb_entry_q <= cb_q ? ram_rdata : '0;
		end
	end

	// pointers reported as four bits
	logic [PTR_W+IDX_W-1:0] head_x, tail_x;

	assign head_x = {{IDX_W{1'b0}}, head_q};
	assign tail_x = {{IDX_W{1'b0}}, tail_q};

	// result register
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {6'b0, tail_x[IDX_W-1:0], head_x[IDX_W-1:0],
				cb_entry_q, ca_entry_q};
			out_user_q <= {cb_q, ca_q};
		end
	end

	assign out_data = out_data_q;
	assign out_user = out_user_q;

`ifndef SYNTHESIS
	a_pend_implies_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q & ~valid_q) == '0)
		else $error("pending entry without valid entry");

	a_ring_full_or_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == tail_q) |-> (valid_q == '0 || valid_q == '1))
		else $error("head meets tail on a partly filled buffer");
`endif

endmodule
